FILE: design/assert_macros.svh
// Assertion macros shared by the blink menu RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: design/sbbm_pkg.sv
// Types and constants of the single button blink menu.
package sbbm_pkg;

   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned PressWidth  = 16;
   localparam int unsigned OptionWidth = 8;
   localparam int unsigned CsrIdxWidth = 8;
   localparam int unsigned CsrDatWidth = 16;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_OPTION_LIMIT    = 8'd0,
      CSR_IDLE_BLINK_MS   = 8'd1,
      CSR_LONG_PRESS_MS   = 8'd2,
      CSR_MENU_TIMEOUT_MS = 8'd3,
      CSR_MENU_GAP_MS     = 8'd4,
      CSR_MENU_BLINK_MS   = 8'd5
   } csr_index_type;

   localparam logic [OptionWidth-1:0] RstOptionLimit  = 8'd1;
   localparam logic [PressWidth-1:0]  RstIdleBlinkMs  = 16'd250;
   localparam logic [PressWidth-1:0]  RstLongPressMs  = 16'd2000;
   localparam logic [PressWidth-1:0]  RstMenuTimeout  = 16'd15000;
   localparam logic [PressWidth-1:0]  RstMenuGapMs    = 16'd1000;
   localparam logic [PressWidth-1:0]  RstMenuBlinkMs  = 16'd350;

   typedef struct packed {
      logic [OptionWidth-1:0] option_limit;
      logic [PressWidth-1:0]  idle_blink_ms;
      logic [PressWidth-1:0]  long_press_ms;
      logic [PressWidth-1:0]  menu_timeout_ms;
      logic [PressWidth-1:0]  menu_gap_ms;
      logic [PressWidth-1:0]  menu_blink_ms;
   } cfg_type;

   typedef struct packed {
      logic [TimeWidth-1:0]  now_ms;
      logic                  released;
      logic [PressWidth-1:0] press_ms;
   } req_type;

   typedef struct packed {
      logic                   led_on;
      logic                   in_menu;
      logic                   chosen_valid;
      logic [OptionWidth-1:0] chosen_option;
   } rsp_type;

endpackage

FILE: design/sbbm_ifaces.sv
// Handshake interfaces for the request, response and register write channels.
interface sbbm_req_if import sbbm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TimeWidth-1:0]  now_ms;
   logic                  released;
   logic [PressWidth-1:0] press_ms;
   modport source (output valid, output now_ms, output released, output press_ms,
                   input ready);
   modport sink (input valid, input now_ms, input released, input press_ms,
                 output ready);
endinterface

interface sbbm_rsp_if import sbbm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   led_on;
   logic                   in_menu;
   logic                   chosen_valid;
   logic [OptionWidth-1:0] chosen_option;
   modport source (output valid, output led_on, output in_menu, output chosen_valid,
                   output chosen_option, input ready);
   modport sink (input valid, input led_on, input in_menu, input chosen_valid,
                 input chosen_option, output ready);
endinterface

interface sbbm_csr_if import sbbm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CsrIdxWidth-1:0] index;
   logic [CsrDatWidth-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/sbbm_csr.sv
// Configuration register file of the blink menu.
module sbbm_csr
   import sbbm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sbbm_csr_if.sink   csr_bus,
   output cfg_type    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_OPTION_LIMIT:    cfg_in.option_limit    = csr_bus.data[OptionWidth-1:0];
            CSR_IDLE_BLINK_MS:   cfg_in.idle_blink_ms   = csr_bus.data;
            CSR_LONG_PRESS_MS:   cfg_in.long_press_ms   = csr_bus.data;
            CSR_MENU_TIMEOUT_MS: cfg_in.menu_timeout_ms = csr_bus.data;
            CSR_MENU_GAP_MS:     cfg_in.menu_gap_ms     = csr_bus.data;
            CSR_MENU_BLINK_MS:   cfg_in.menu_blink_ms   = csr_bus.data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.option_limit    <= RstOptionLimit;
         cfg_ff.idle_blink_ms   <= RstIdleBlinkMs;
         cfg_ff.long_press_ms   <= RstLongPressMs;
         cfg_ff.menu_timeout_ms <= RstMenuTimeout;
         cfg_ff.menu_gap_ms     <= RstMenuGapMs;
         cfg_ff.menu_blink_ms   <= RstMenuBlinkMs;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/sbbm_core.sv
// Mode state and per-tick update logic of the blink menu.
`include "assert_macros.svh"
module sbbm_core
   import sbbm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic                   menu_ff, menu_in;
   logic                   led_ff, led_in;
   logic                   phase_ff, phase_in;
   logic [TimeWidth-1:0]   blink_due_ff, blink_due_in;
   logic [TimeWidth-1:0]   activity_ff, activity_in;
   logic [OptionWidth-1:0] option_ff, option_in;
   logic [TimeWidth-1:0]   shown_due_ff, shown_due_in;
   logic [OptionWidth-1:0] count_ff, count_in;
   logic                   shown_phase_ff, shown_phase_in;

   logic [TimeWidth-1:0] idle_due_sum;
   logic [TimeWidth-1:0] blink_sum;
   logic [TimeWidth-1:0] gap_sum;
   logic [TimeWidth-1:0] timeout_at;
   logic                 is_long;
   logic                 chose;

   assign idle_due_sum = item.now_ms + {{(TimeWidth-PressWidth){1'b0}}, cfg.idle_blink_ms};
   assign blink_sum    = item.now_ms + {{(TimeWidth-PressWidth){1'b0}}, cfg.menu_blink_ms};
   assign gap_sum      = item.now_ms + {{(TimeWidth-PressWidth){1'b0}}, cfg.menu_gap_ms};
   assign is_long      = item.press_ms > cfg.long_press_ms;
   assign chose        = step && result.chosen_valid;

   always_comb begin
      menu_in        = menu_ff;
      led_in         = led_ff;
      phase_in       = phase_ff;
      blink_due_in   = blink_due_ff;
      activity_in    = activity_ff;
      option_in      = option_ff;
      shown_due_in   = shown_due_ff;
      count_in       = count_ff;
      shown_phase_in = shown_phase_ff;
      timeout_at     = '0;
      result.chosen_valid  = 1'b0;
      result.chosen_option = '0;

      if (!menu_ff) begin
         if (item.now_ms > blink_due_ff) begin
            phase_in     = !phase_ff;
            led_in       = !phase_ff;
            blink_due_in = idle_due_sum;
         end
         if (item.released && !(item.press_ms < cfg.long_press_ms)) begin
            menu_in        = 1'b1;
            activity_in    = item.now_ms;
            option_in      = {{(OptionWidth-1){1'b0}}, 1'b1};
            count_in       = {{(OptionWidth-1){1'b0}}, 1'b1};
            shown_due_in   = '0;
            shown_phase_in = 1'b0;
         end
      end else begin
         if (shown_due_ff <= item.now_ms) begin
            if (!shown_phase_ff) begin
               led_in         = 1'b0;
               shown_due_in   = blink_sum;
               shown_phase_in = 1'b1;
            end else begin
               led_in = 1'b1;
               if (count_ff >= option_ff) begin
                  shown_due_in = gap_sum;
                  count_in     = {{(OptionWidth-1){1'b0}}, 1'b1};
               end else begin
                  shown_due_in = blink_sum;
                  count_in     = count_ff + {{(OptionWidth-1){1'b0}}, 1'b1};
               end
               shown_phase_in = 1'b0;
            end
         end
         if (item.released) begin
            activity_in = item.now_ms;
            if (!is_long) begin
               if (option_ff >= cfg.option_limit) begin
                  option_in = {{(OptionWidth-1){1'b0}}, 1'b1};
               end else begin
                  option_in = option_ff + {{(OptionWidth-1){1'b0}}, 1'b1};
               end
            end else begin
               result.chosen_valid  = 1'b1;
               result.chosen_option = option_ff;
               menu_in              = 1'b0;
               phase_in             = 1'b0;
               blink_due_in         = '0;
            end
         end
         timeout_at = activity_in + {{(TimeWidth-PressWidth){1'b0}}, cfg.menu_timeout_ms};
         if (menu_in && item.now_ms > timeout_at) begin
            menu_in      = 1'b0;
            phase_in     = 1'b0;
            blink_due_in = '0;
         end
      end

      result.led_on  = led_in;
      result.in_menu = menu_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         menu_ff        <= 1'b0;
         led_ff         <= 1'b0;
         phase_ff       <= 1'b0;
         blink_due_ff   <= '0;
         activity_ff    <= '0;
         option_ff      <= {{(OptionWidth-1){1'b0}}, 1'b1};
         shown_due_ff   <= '0;
         count_ff       <= {{(OptionWidth-1){1'b0}}, 1'b1};
         shown_phase_ff <= 1'b0;
      end else if (step) begin
         menu_ff        <= menu_in;
         led_ff         <= led_in;
         phase_ff       <= phase_in;
         blink_due_ff   <= blink_due_in;
         activity_ff    <= activity_in;
         option_ff      <= option_in;
         shown_due_ff   <= shown_due_in;
         count_ff       <= count_in;
         shown_phase_ff <= shown_phase_in;
      end
   end

   `ASSERT_NEVER(a_option_nonzero, clock, reset, option_ff == '0, "menu option is zero")
   `ASSERT_NEVER(a_count_nonzero, clock, reset, count_ff == '0, "blink count is zero")
   `ASSERT_AT(a_choice_leaves_menu, clock, reset, chose |=> !menu_ff, "choice kept menu open")
   `ASSERT_AT(a_idle_no_choice, clock, reset, !menu_ff |-> !result.chosen_valid, "choice in idle")

endmodule

FILE: design/single_button_blink_menu.sv
// Top level of the single button blink menu: input register, update logic, result register.
//
//   channel  | bus      | direction | payload
//   ---------+----------+-----------+-----------------------------------------------
//   request  | req_bus  | in        | now_ms, released, press_ms
//   response | rsp_bus  | out       | led_on, in_menu, chosen_valid, chosen_option
//   config   | csr_bus  | in        | index, data (always ready)
//
// One transaction per cycle sustained while rsp_bus is ready; a request passes the input
// register, then the update logic into the result register.
// The state registers update as the registered request moves into the result register.
// Synchronous reset restores the register defaults and the idle state.
// A stalled response holds the result register; the input register still takes one more.
`include "assert_macros.svh"
module single_button_blink_menu
   import sbbm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sbbm_req_if.sink   req_bus,
   sbbm_rsp_if.source rsp_bus,
   sbbm_csr_if.sink   csr_bus
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    advance;
   logic    take;
   cfg_type cfg;
   rsp_type result;

   sbbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   sbbm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.led_on        = out_data_ff.led_on;
   assign rsp_bus.in_menu       = out_data_ff.in_menu;
   assign rsp_bus.chosen_valid  = out_data_ff.chosen_valid;
   assign rsp_bus.chosen_option = out_data_ff.chosen_option;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff.now_ms   <= req_bus.now_ms;
         in_data_ff.released <= req_bus.released;
         in_data_ff.press_ms <= req_bus.press_ms;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   `ASSERT_AT(a_advance_fills_out, clock, reset, advance |=> out_valid_ff, "result lost")
   `ASSERT_AT(a_stall_keeps_input, clock, reset, in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff), "input dropped")
   `ASSERT_AT(a_no_advance_when_blocked, clock, reset, out_valid_ff && !rsp_bus.ready |-> !advance, "overwrote held result")

endmodule
